// File: rtl/assert_macros.svh
// Assertion macros used by the dual UART ring block RTL.
// Each macro samples on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while rst is low.
`define UDRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked during reset as well.
`define UDRF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/udrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udrf_pkg
// Operation codes, ring sizes and pointer helpers for the dual UART ring block.
// ----------------------------------------------------------------------------
package udrf_pkg;

  localparam int TX_DEPTH = 64;
  localparam int RX_DEPTH = 64;
  localparam int TX_AW    = $clog2(TX_DEPTH);
  localparam int RX_AW    = $clog2(RX_DEPTH);
  localparam int TX_FW    = $clog2(TX_DEPTH + 1);
  localparam int RX_FW    = $clog2(RX_DEPTH + 1);
  localparam int LEVEL_W  = 7;

  typedef logic [2:0] op_t;

  localparam op_t OP_PUSH   = 3'd0;
  localparam op_t OP_POP    = 3'd1;
  localparam op_t OP_ARRIVE = 3'd2;
  localparam op_t OP_READY  = 3'd3;
  localparam op_t OP_DONE   = 3'd4;
  localparam op_t OP_CLR_TX = 3'd5;
  localparam op_t OP_CLR_RX = 3'd6;

  function automatic logic [TX_AW-1:0] tx_bump(input logic [TX_AW-1:0] p);
    return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + TX_AW'(1);
  endfunction

  function automatic logic [RX_AW-1:0] rx_bump(input logic [RX_AW-1:0] p);
    return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + RX_AW'(1);
  endfunction

endpackage

// File: rtl/uart_dual_ring_fifo_irq.sv
`timescale 1ns / 1ps
// An item's result is registered and shown in the cycle after acceptance.
// One item per cycle unless the output stalls; each ring memory has one
// write and one registered read port, and an item touches at most one entry
// of one ring. Reset clears pointers, fill counts, enables and the busy flag;
// the byte stores are not cleared and hold no valid data until written.
// ----------------------------------------------------------------------------
// uart_dual_ring_fifo_irq
// Transmit and receive byte rings with interrupt-style transmit sequencing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uart_dual_ring_fifo_irq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    operation,
  input  logic [7:0]                    data_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          accepted,
  output logic                          line_valid,
  output logic [7:0]                    line_byte,
  output logic [7:0]                    read_byte,
  output logic                          rx_overflow,
  output logic                          send_done,
  output logic                          sending,
  output logic                          tx_irq_enable,
  output logic                          done_irq_enable,
  output logic [udrf_pkg::LEVEL_W-1:0]  tx_level,
  output logic [udrf_pkg::LEVEL_W-1:0]  rx_level
);
  import udrf_pkg::*;

  logic [7:0]       tx_store [TX_DEPTH];
  logic [7:0]       rx_store [RX_DEPTH];
  logic [7:0]       tx_rdata;
  logic [7:0]       rx_rdata;

  logic [TX_AW-1:0] tx_head, tx_head_next, tx_tail, tx_tail_next;
  logic [TX_FW-1:0] tx_fill, tx_fill_next;
  logic [RX_AW-1:0] rx_head, rx_head_next, rx_tail, rx_tail_next;
  logic [RX_FW-1:0] rx_fill, rx_fill_next;
  logic             busy_flag, busy_flag_next;
  logic             ready_enable, ready_enable_next;
  logic             complete_enable, complete_enable_next;

  logic             tx_we, rx_we;
  logic             in_acc;
  logic             acc_next, lv_next, ovf_next, done_next, pop_next;
  logic             pop_hit;

  assign in_stall = out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    tx_head_next         = tx_head;
    tx_tail_next         = tx_tail;
    tx_fill_next         = tx_fill;
    rx_head_next         = rx_head;
    rx_tail_next         = rx_tail;
    rx_fill_next         = rx_fill;
    busy_flag_next       = busy_flag;
    ready_enable_next    = ready_enable;
    complete_enable_next = complete_enable;
    tx_we                = 1'b0;
    rx_we                = 1'b0;
    acc_next             = 1'b0;
    lv_next              = 1'b0;
    ovf_next             = 1'b0;
    done_next            = 1'b0;
    pop_next             = 1'b0;
    if (in_acc) begin
      case (operation)
        OP_PUSH: begin
          if (tx_fill < TX_FW'(TX_DEPTH)) begin
            tx_we        = 1'b1;
            tx_head_next = tx_bump(tx_head);
            tx_fill_next = tx_fill + TX_FW'(1);
            acc_next     = 1'b1;
          end
          ready_enable_next = 1'b1;
        end
        OP_POP: begin
          if (rx_fill != '0) begin
            rx_tail_next = rx_bump(rx_tail);
            rx_fill_next = rx_fill - RX_FW'(1);
            acc_next     = 1'b1;
            pop_next     = 1'b1;
          end
        end
        OP_ARRIVE: begin
          if (rx_fill == RX_FW'(RX_DEPTH)) begin
            rx_tail_next = rx_bump(rx_tail);
            ovf_next     = 1'b1;
          end else begin
            rx_fill_next = rx_fill + RX_FW'(1);
          end
          rx_we        = 1'b1;
          rx_head_next = rx_bump(rx_head);
          acc_next     = 1'b1;
        end
        OP_READY: begin
          if (ready_enable) begin
            if (tx_fill == '0) begin
              ready_enable_next    = 1'b0;
              complete_enable_next = 1'b1;
            end else begin
              busy_flag_next = 1'b1;
              tx_tail_next   = tx_bump(tx_tail);
              tx_fill_next   = tx_fill - TX_FW'(1);
              lv_next        = 1'b1;
            end
          end
        end
        OP_DONE: begin
          if (complete_enable) begin
            if (tx_fill == '0) begin
              complete_enable_next = 1'b0;
              busy_flag_next       = 1'b0;
              done_next            = 1'b1;
            end else begin
              tx_tail_next = tx_bump(tx_tail);
              tx_fill_next = tx_fill - TX_FW'(1);
              lv_next      = 1'b1;
            end
          end
        end
        OP_CLR_TX: begin
          tx_head_next = '0;
          tx_tail_next = '0;
          tx_fill_next = '0;
        end
        OP_CLR_RX: begin
          rx_head_next = '0;
          rx_tail_next = '0;
          rx_fill_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_store[tx_head] <= data_in;
    end
    if (in_acc) begin
      tx_rdata <= tx_store[tx_tail];
    end
  end

  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_store[rx_head] <= data_in;
    end
    if (in_acc) begin
      rx_rdata <= rx_store[rx_tail];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_head         <= '0;
      tx_tail         <= '0;
      tx_fill         <= '0;
      rx_head         <= '0;
      rx_tail         <= '0;
      rx_fill         <= '0;
      busy_flag       <= 1'b0;
      ready_enable    <= 1'b0;
      complete_enable <= 1'b0;
      out_valid       <= 1'b0;
      accepted        <= 1'b0;
      line_valid      <= 1'b0;
      rx_overflow     <= 1'b0;
      send_done       <= 1'b0;
      pop_hit         <= 1'b0;
    end else begin
      tx_head         <= tx_head_next;
      tx_tail         <= tx_tail_next;
      tx_fill         <= tx_fill_next;
      rx_head         <= rx_head_next;
      rx_tail         <= rx_tail_next;
      rx_fill         <= rx_fill_next;
      busy_flag       <= busy_flag_next;
      ready_enable    <= ready_enable_next;
      complete_enable <= complete_enable_next;
      if (in_acc) begin
        out_valid   <= 1'b1;
        accepted    <= acc_next;
        line_valid  <= lv_next;
        rx_overflow <= ovf_next;
        send_done   <= done_next;
        pop_hit     <= pop_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign line_byte       = line_valid ? tx_rdata : 8'd0;
  assign read_byte       = pop_hit ? rx_rdata : 8'd0;
  assign sending         = busy_flag;
  assign tx_irq_enable   = ready_enable;
  assign done_irq_enable = complete_enable;
  assign tx_level        = LEVEL_W'(tx_fill);
  assign rx_level        = LEVEL_W'(rx_fill);

  `UDRF_ASSERT(a_fill_bound, (tx_fill <= TX_FW'(TX_DEPTH)) && (rx_fill <= RX_FW'(RX_DEPTH)), "ring fill count beyond depth")
  `UDRF_ASSERT(a_push_grows, (in_acc && operation == OP_PUSH && tx_fill < TX_FW'(TX_DEPTH)) |=> (tx_fill == $past(tx_fill) + TX_FW'(1)), "push with room did not grow the transmit ring")
  `UDRF_ASSERT(a_send_or_done, out_valid |-> !(line_valid && send_done), "byte sent and send done in one result")
  `UDRF_ASSERT(a_done_idle, (out_valid && send_done) |-> (!sending && tx_level == '0), "send done while transmitter still busy")
  `UDRF_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid, "result pending right after reset")

endmodule

// File: test/udrf_ring_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udrf_ring_monitor
// Watches both channels of the dual UART ring block. It keeps its own copy of
// the transmit and receive rings, works out the status and event fields for
// every accepted item, and compares each accepted result against them.
// ----------------------------------------------------------------------------
module udrf_ring_monitor (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  udrf_pkg::op_t                operation,
  input  logic [7:0]                   data_in,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         accepted,
  input  logic                         line_valid,
  input  logic [7:0]                   line_byte,
  input  logic [7:0]                   read_byte,
  input  logic                         rx_overflow,
  input  logic                         send_done,
  input  logic                         sending,
  input  logic                         tx_irq_enable,
  input  logic                         done_irq_enable,
  input  logic [udrf_pkg::LEVEL_W-1:0] tx_level,
  input  logic [udrf_pkg::LEVEL_W-1:0] rx_level,
  output int                           mismatches,
  output int                           outcomes_waiting
);
  import udrf_pkg::*;

  typedef struct packed {
    logic               accepted;
    logic               line_valid;
    logic [7:0]         line_byte;
    logic [7:0]         read_byte;
    logic               rx_overflow;
    logic               send_done;
    logic               sending;
    logic               tx_irq_enable;
    logic               done_irq_enable;
    logic [LEVEL_W-1:0] tx_level;
    logic [LEVEL_W-1:0] rx_level;
  } ring_outcome_t;

  logic [7:0]       tx_mem [TX_DEPTH];
  logic [7:0]       rx_mem [RX_DEPTH];
  logic [TX_AW-1:0] tx_wr, tx_rd;
  logic [RX_AW-1:0] rx_wr, rx_rd;
  logic [TX_FW-1:0] tx_cnt;
  logic [RX_FW-1:0] rx_cnt;
  logic             busy, rdy_en, cmp_en;

  ring_outcome_t outcome_q [$];

  task automatic send_oldest_tx(inout ring_outcome_t r);
    r.line_byte  = tx_mem[tx_rd];
    r.line_valid = 1'b1;
    tx_rd        = TX_AW'((tx_rd + 1) % TX_DEPTH);
    tx_cnt       = tx_cnt - TX_FW'(1);
  endtask

  task automatic advance_rings(input op_t op, input logic [7:0] d,
                               output ring_outcome_t r);
    r = '0;
    case (op)
      OP_PUSH: begin
        if (tx_cnt < TX_FW'(TX_DEPTH)) begin
          tx_mem[tx_wr] = d;
          tx_wr         = TX_AW'((tx_wr + 1) % TX_DEPTH);
          tx_cnt        = tx_cnt + TX_FW'(1);
          r.accepted    = 1'b1;
        end
        rdy_en = 1'b1;
      end
      OP_POP: begin
        if (rx_cnt != '0) begin
          r.read_byte = rx_mem[rx_rd];
          rx_rd       = RX_AW'((rx_rd + 1) % RX_DEPTH);
          rx_cnt      = rx_cnt - RX_FW'(1);
          r.accepted  = 1'b1;
        end
      end
      OP_ARRIVE: begin
        // A full ring loses its oldest byte to make room.
        if (rx_cnt >= RX_FW'(RX_DEPTH)) begin
          rx_rd         = RX_AW'((rx_rd + 1) % RX_DEPTH);
          r.rx_overflow = 1'b1;
        end else begin
          rx_cnt = rx_cnt + RX_FW'(1);
        end
        rx_mem[rx_wr] = d;
        rx_wr         = RX_AW'((rx_wr + 1) % RX_DEPTH);
        r.accepted    = 1'b1;
      end
      OP_READY: begin
        if (rdy_en) begin
          if (tx_cnt == '0) begin
            rdy_en = 1'b0;
            cmp_en = 1'b1;
          end else begin
            busy = 1'b1;
            send_oldest_tx(r);
          end
        end
      end
      OP_DONE: begin
        if (cmp_en) begin
          if (tx_cnt == '0) begin
            cmp_en      = 1'b0;
            r.send_done = 1'b1;
            busy        = 1'b0;
          end else begin
            send_oldest_tx(r);
          end
        end
      end
      OP_CLR_TX: begin
        tx_wr  = '0;
        tx_rd  = '0;
        tx_cnt = '0;
      end
      OP_CLR_RX: begin
        rx_wr  = '0;
        rx_rd  = '0;
        rx_cnt = '0;
      end
      default: begin
      end
    endcase
    r.sending         = busy;
    r.tx_irq_enable   = rdy_en;
    r.done_irq_enable = cmp_en;
    r.tx_level        = LEVEL_W'(tx_cnt);
    r.rx_level        = LEVEL_W'(rx_cnt);
  endtask

  always @(posedge clk) begin : watch
    ring_outcome_t seen;
    ring_outcome_t want;
    if (rst) begin
      tx_wr  = '0;
      tx_rd  = '0;
      tx_cnt = '0;
      rx_wr  = '0;
      rx_rd  = '0;
      rx_cnt = '0;
      busy   = 1'b0;
      rdy_en = 1'b0;
      cmp_en = 1'b0;
      outcome_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen = {accepted, line_valid, line_byte, read_byte, rx_overflow, send_done,
                sending, tx_irq_enable, done_irq_enable, tx_level, rx_level};
        if (outcome_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result arrived with no item outstanding", $realtime);
          end
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          if (seen !== want) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch want acc=%b lv=%b lb=%h rb=%h ovf=%b done=%b",
                       $realtime, want.accepted, want.line_valid, want.line_byte,
                       want.read_byte, want.rx_overflow, want.send_done);
              $display("    snd=%b txe=%b dne=%b txl=%0d rxl=%0d", want.sending,
                       want.tx_irq_enable, want.done_irq_enable, want.tx_level,
                       want.rx_level);
              $display("  got acc=%b lv=%b lb=%h rb=%h ovf=%b done=%b",
                       seen.accepted, seen.line_valid, seen.line_byte,
                       seen.read_byte, seen.rx_overflow, seen.send_done);
              $display("    snd=%b txe=%b dne=%b txl=%0d rxl=%0d", seen.sending,
                       seen.tx_irq_enable, seen.done_irq_enable, seen.tx_level,
                       seen.rx_level);
            end
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        advance_rings(operation, data_in, want);
        outcome_q.push_back(want);
      end
    end
    outcomes_waiting = outcome_q.size();
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the dual UART ring block with a short directed sequence and then
// bursts of pushes, arrivals, transmit drains, pops, clears and mixed items
// with random data, under three idling mixes and one long output hold-off.
// The ring monitor checks each result and counts failures for the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import udrf_pkg::*;

  localparam op_t OP_UNUSED       = 3'd7;
  localparam int  CYCLE_LIMIT     = 400000;
  localparam int  ITEMS_PER_PHASE = 430;
  localparam int  HOLD_CYCLES     = 300;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  op_t                operation = OP_PUSH;
  logic [7:0]         data_in   = 8'h00;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic               accepted;
  logic               line_valid;
  logic [7:0]         line_byte;
  logic [7:0]         read_byte;
  logic               rx_overflow;
  logic               send_done;
  logic               sending;
  logic               tx_irq_enable;
  logic               done_irq_enable;
  logic [LEVEL_W-1:0] tx_level;
  logic [LEVEL_W-1:0] rx_level;

  int send_idle_pct = 33;
  int recv_idle_pct = 75;
  int phase_items   = 0;
  int cycle_count   = 0;
  int mismatches;
  int outcomes_waiting;
  bit hold_req      = 1'b0;
  bit hold_off      = 1'b0;

  always #1 clk = ~clk;

  uart_dual_ring_fifo_irq u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .data_in         (data_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .accepted        (accepted),
    .line_valid      (line_valid),
    .line_byte       (line_byte),
    .read_byte       (read_byte),
    .rx_overflow     (rx_overflow),
    .send_done       (send_done),
    .sending         (sending),
    .tx_irq_enable   (tx_irq_enable),
    .done_irq_enable (done_irq_enable),
    .tx_level        (tx_level),
    .rx_level        (rx_level)
  );

  udrf_ring_monitor u_check (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .operation        (operation),
    .data_in          (data_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .accepted         (accepted),
    .line_valid       (line_valid),
    .line_byte        (line_byte),
    .read_byte        (read_byte),
    .rx_overflow      (rx_overflow),
    .send_done        (send_done),
    .sending          (sending),
    .tx_irq_enable    (tx_irq_enable),
    .done_irq_enable  (done_irq_enable),
    .tx_level         (tx_level),
    .rx_level         (rx_level),
    .mismatches       (mismatches),
    .outcomes_waiting (outcomes_waiting)
  );

  always @(negedge clk) begin
    if (hold_off) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Entered and left at a falling edge.
  task automatic offer_item(input op_t op, input logic [7:0] d);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    data_in   <= d;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (op != OP_UNUSED) begin
      phase_items++;
    end
  endtask

  task automatic random_burst();
    int kind;
    int len;
    kind = $urandom_range(0, 9);
    len  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 8);
    case (kind)
      0, 1: repeat (len) offer_item(OP_PUSH, 8'($urandom_range(0, 255)));
      2, 3: repeat (len) offer_item(OP_ARRIVE, 8'($urandom_range(0, 255)));
      4, 5: begin
        repeat (len) offer_item(OP_READY, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(1, 3)) offer_item(OP_DONE, 8'($urandom_range(0, 255)));
      end
      6, 7: repeat (len) offer_item(OP_POP, 8'($urandom_range(0, 255)));
      8: repeat ($urandom_range(1, 6)) begin
        offer_item(op_t'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      end
      default: offer_item($urandom_range(0, 1) ? OP_CLR_TX : OP_CLR_RX,
                          8'($urandom_range(0, 255)));
    endcase
  endtask

  initial begin : hold_off_gen
    int held;
    wait (hold_req);
    @(posedge clk);
    hold_off = 1'b1;
    for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("uart_dual_ring_fifo_irq verification failed");
    $finish;
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    offer_item(OP_POP, 8'h00);
    offer_item(OP_READY, 8'hFF);
    offer_item(OP_DONE, 8'h00);
    offer_item(OP_PUSH, 8'h00);
    offer_item(OP_PUSH, 8'hFF);
    offer_item(OP_READY, 8'h00);
    offer_item(OP_READY, 8'h00);
    offer_item(OP_READY, 8'h00);
    offer_item(OP_PUSH, 8'h3C);
    offer_item(OP_DONE, 8'h00);
    offer_item(OP_DONE, 8'h00);
    offer_item(OP_ARRIVE, 8'h00);
    offer_item(OP_ARRIVE, 8'hFF);
    offer_item(OP_POP, 8'h00);
    offer_item(OP_POP, 8'h00);
    offer_item(OP_POP, 8'h00);
    offer_item(OP_ARRIVE, 8'h12);
    offer_item(OP_CLR_RX, 8'h00);
    offer_item(OP_POP, 8'h00);
    offer_item(OP_PUSH, 8'h80);
    offer_item(OP_CLR_TX, 8'h00);
    offer_item(OP_READY, 8'h00);
    offer_item(OP_DONE, 8'h00);
    offer_item(OP_UNUSED, 8'h55);
    offer_item(OP_UNUSED, 8'hAA);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 75;
        end
        1: begin
          send_idle_pct = 75;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req      = 1'b1;
        end
      endcase
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) random_burst();
    end
    in_valid <= 1'b0;

    while (outcomes_waiting != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outcomes_waiting == 0) begin
      $display("uart_dual_ring_fifo_irq verification clean");
    end else begin
      $display("uart_dual_ring_fifo_irq verification failed");
    end
    $finish;
  end

endmodule
